@@ rtl/hpmc_pkg.sv @@
package hpmc_pkg;

    // widest block the line buffer is sized for
    localparam int MAX_BLOCK_WIDTH = 16;

    localparam int PIX_W   = 8;
    localparam int DEPTH   = MAX_BLOCK_WIDTH + 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    // column and row counters run 0..w inclusive
    localparam int CNT_W   = $clog2(MAX_BLOCK_WIDTH + 1);

    localparam logic [CNT_W-1:0] BLOCK_SMALL = CNT_W'(8);
    localparam logic [CNT_W-1:0] BLOCK_LARGE = CNT_W'(16);

    // interpolation modes, {half_y, half_x}
    localparam logic [1:0] MODE_COPY  = 2'b00;
    localparam logic [1:0] MODE_HORIZ = 2'b01;
    localparam logic [1:0] MODE_VERT  = 2'b10;
    localparam logic [1:0] MODE_DIAG  = 2'b11;

    // one pixel in flight between the line buffer read and the filter
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [1:0]       mode;
        logic             emit;
        logic             last;
    } stage_t;

endpackage

@@ rtl/half_pel_motion_compensation.sv @@
// half-pel motion compensation for one 8x8 or 16x16 block
//
// input channel (in_valid / in_ready): one reference window pixel per
// transaction, raster order, (w+1)x(w+1) pixels per window. window_start
// marks row 0 column 0 and latches half_x, half_y and large_block; after the
// last window pixel the counters wrap and a new window follows with the same
// mode. output channel (out_valid / out_ready): the w x w prediction in raster
// order, block_last on the final pixel. config channel (cfg_valid /
// cfg_ready, always ready): rounding_control, 0 rounds averages up, 1 down.
//
// throughput is one pixel per cycle while out_ready is high: the line buffer
// ram is read and written at the same column in the accept cycle, so
// back-to-back pixels wait only on output back-pressure. the accept edge
// loads the filter stage and the line buffer read, the advance of the filter
// stage loads the output register. pixels of the extra row or column yield
// no output. when out_ready is low the output register holds, one more pixel
// waits in the filter stage, and in_ready drops only then.
// reset clears counters, mode, neighbor pixels and rounding; the line buffer
// is not cleared since no read of an unwritten entry reaches an output.
module half_pel_motion_compensation (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [hpmc_pkg::PIX_W-1:0] ref_pixel,
    input  logic                      half_x,
    input  logic                      half_y,
    input  logic                      large_block,
    input  logic                      window_start,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [hpmc_pkg::PIX_W-1:0] predicted_pixel,
    output logic                      block_last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      rounding_control
);

    localparam int CW = hpmc_pkg::CNT_W;
    localparam int PW = hpmc_pkg::PIX_W;

    // configuration
    logic round_reg;

    // window position and latched mode
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [2:0]    mode_reg, mode_next;

    // filter stage
    logic             s1_valid_reg;
    hpmc_pkg::stage_t s1_reg, s1_next;
    logic [PW-1:0]    left_reg;
    logic [PW-1:0]    upleft_reg;
    logic [PW-1:0]    above;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] pred_reg, pred_next;
    logic          last_reg;

    logic          in_accept;
    logic          s1_advance;
    logic [CW-1:0] cur_col, cur_row, cur_w, off_col, off_row;
    logic          cur_hx, cur_hy;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    // position of the arriving pixel, window start restarts everything
    always_comb
    begin
        mode_next = window_start ? {large_block, half_y, half_x} : mode_reg;
        cur_col   = window_start ? '0 : col_reg;
        cur_row   = window_start ? '0 : row_reg;
        cur_hx    = mode_next[0];
        cur_hy    = mode_next[1];
        cur_w     = mode_next[2] ? hpmc_pkg::BLOCK_LARGE : hpmc_pkg::BLOCK_SMALL;
        off_col   = cur_col - CW'(cur_hx);
        off_row   = cur_row - CW'(cur_hy);

        if (cur_col >= cur_w)
        begin
            col_next = '0;
            row_next = (cur_row >= cur_w) ? '0 : cur_row + CW'(1);
        end
        else
        begin
            col_next = cur_col + CW'(1);
            row_next = cur_row;
        end

        s1_next.pix  = ref_pixel;
        s1_next.mode = {cur_hy, cur_hx};
        s1_next.emit = (cur_col >= CW'(cur_hx)) && (cur_row >= CW'(cur_hy))
                       && (off_col < cur_w) && (off_row < cur_w);
        s1_next.last = (off_col == cur_w - CW'(1)) && (off_row == cur_w - CW'(1));
    end

    // line buffer: the read of the pixel above is registered at the accept, alongside the filter stage
    hpmc_ram #(
        .WIDTH(PW),
        .DEPTH(hpmc_pkg::DEPTH)
    ) u_line_buf (
        .clk  (clk),
        .we   (in_accept),
        .waddr(cur_col[hpmc_pkg::ADDR_W-1:0]),
        .wdata(ref_pixel),
        .re   (in_accept),
        .raddr(cur_col[hpmc_pkg::ADDR_W-1:0]),
        .rdata(above)
    );

    // 2-tap and 4-tap averages with the selected rounding
    always_comb
    begin
        logic [PW:0]   sum_h;
        logic [PW:0]   sum_v;
        logic [PW+1:0] sum_d;
        sum_h = {1'b0, left_reg} + {1'b0, s1_reg.pix} + (PW+1)'(!round_reg);
        sum_v = {1'b0, above} + {1'b0, s1_reg.pix} + (PW+1)'(!round_reg);
        sum_d = {2'b00, upleft_reg} + {2'b00, above} + {2'b00, left_reg}
                + {2'b00, s1_reg.pix} + (round_reg ? (PW+2)'(1) : (PW+2)'(2));
        case (s1_reg.mode)
            hpmc_pkg::MODE_COPY:  pred_next = s1_reg.pix;
            hpmc_pkg::MODE_HORIZ: pred_next = sum_h[PW:1];
            hpmc_pkg::MODE_VERT:  pred_next = sum_v[PW:1];
            hpmc_pkg::MODE_DIAG:  pred_next = sum_d[PW+1:2];
            default:              pred_next = s1_reg.pix;
        endcase

        if (s1_advance)
        begin
            out_valid_next = s1_reg.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            mode_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            left_reg      <= '0;
            upleft_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                round_reg <= rounding_control;
            end
            if (in_accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                mode_reg <= mode_next;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            // neighbors move on as each pixel leaves the filter stage
            if (s1_advance)
            begin
                left_reg   <= s1_reg.pix;
                upleft_reg <= above;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_advance)
        begin
            pred_reg <= pred_next;
            last_reg <= s1_reg.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign predicted_pixel = pred_reg;
    assign block_last      = last_reg;

    // counters stay inside the window of the latched size
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= (mode_reg[2] ? hpmc_pkg::BLOCK_LARGE : hpmc_pkg::BLOCK_SMALL))
        && (row_reg <= (mode_reg[2] ? hpmc_pkg::BLOCK_LARGE : hpmc_pkg::BLOCK_SMALL)))
        else $error("window counter beyond block size");

    // input back-pressure only while the filter stage holds a stalled pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a waiting pixel");

    // a stalled filter stage keeps its pixel and the line buffer data
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_reg) && $stable(above)))
        else $error("filter stage lost its pixel");

    // an accepted pixel always reaches the filter stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted pixel dropped");

endmodule

@@ rtl/hpmc_ram.sv @@
module hpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-before-write on a shared address, data held while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
